>>> hdl/tet_pkg.sv
// ----------------------------------------------------------------------------
// tet_pkg
// Shared types, codes and constants of the terminal escape tokenizer.
// ----------------------------------------------------------------------------
package tet_pkg;

    localparam int SEQ_BYTES  = 40;
    localparam int MAX_PARAMS = 16;

    localparam int STORED_W = 6;
    localparam int COUNT_W  = 5;
    localparam int INDEX_W  = 4;
    localparam int VALUE_W  = 16;
    localparam int AGE_W    = 16;
    localparam int STR_W    = 24;
    localparam int CFG_W    = 24;
    localparam int TDATA_W  = 48;

    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_CSI   = 8'h5b;
    localparam logic [7:0] CH_SS3   = 8'h4f;
    localparam logic [7:0] CH_APC   = 8'h5f;
    localparam logic [7:0] CH_DCS   = 8'h50;
    localparam logic [7:0] CH_OSC   = 8'h5d;
    localparam logic [7:0] CH_PM    = 8'h5e;
    localparam logic [7:0] CH_ST    = 8'h5c;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] FINAL_LO = 8'h40;
    localparam logic [7:0] FINAL_HI = 8'h7e;

    localparam logic [AGE_W-1:0] ESC_TIMEOUT_RST = 16'd50;
    localparam logic [STR_W-1:0] STR_LIMIT_RST   = 24'h100000;
    localparam logic [VALUE_W-1:0] VALUE_MAX     = 16'hffff;
    localparam logic [AGE_W-1:0] AGE_MAX         = 16'hffff;

    localparam logic CFG_ESC_TIMEOUT = 1'b0;
    localparam logic CFG_STR_LIMIT   = 1'b1;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_ESC   = 2'd1,
        KIND_PARAM = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        SEL_PLAIN,
        SEL_ESCKEY,
        SEL_PARAM_FIRST,
        SEL_PARAM_NEXT,
        SEL_HELD_BYTE
    } t_out_sel;

    typedef enum logic [6:0] {
        S_NORMAL     = 7'b0000001,
        S_ESC        = 7'b0000010,
        S_SEQ        = 7'b0000100,
        S_STR        = 7'b0001000,
        S_STR_ESC    = 7'b0010000,
        S_EMIT_BYTE  = 7'b0100000,
        S_EMIT_PARAM = 7'b1000000
    } t_state;

    typedef struct packed {
        logic     load_out;
        t_out_sel out_sel;
        logic     out_last;
        logic     hold_byte;
        logic     age_clr;
        logic     age_tick;
        logic     str_clr;
        logic     str_inc;
        logic     seq_open;
        logic     seq_store;
        logic     seq_final;
        logic     emit_next;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tick;
        logic byte_esc;
        logic byte_intro;
        logic byte_str;
        logic byte_final;
        logic byte_bel;
        logic byte_st;
        logic age_expired;
        logic str_full;
        logic out_free;
        logic final_multi;
        logic emit_last;
    } t_dp_stat;

endpackage

>>> hdl/tet_ctrl.sv
// ----------------------------------------------------------------------------
// tet_ctrl
// Parser state machine: steers the datapath one beat at a time and sequences
// the extra result beats of an Escape-plus-byte pair or a parameter list.
// ----------------------------------------------------------------------------
module tet_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tet_pkg::t_dp_stat i_stat,
    output tet_pkg::t_dp_cmd  o_cmd
);

    tet_pkg::t_state r_state;
    tet_pkg::t_state n_state;
    logic            parse_state;
    logic            accept;

    assign parse_state = (r_state == tet_pkg::S_NORMAL) || (r_state == tet_pkg::S_ESC) ||
                         (r_state == tet_pkg::S_SEQ) || (r_state == tet_pkg::S_STR) ||
                         (r_state == tet_pkg::S_STR_ESC);
    assign o_in_ready  = parse_state && i_stat.out_free;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            tet_pkg::S_NORMAL: begin
                if (accept && !i_stat.is_tick) begin
                    if (i_stat.byte_esc) begin
                        o_cmd.age_clr = 1'b1;
                        n_state       = tet_pkg::S_ESC;
                    end else begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.out_sel  = tet_pkg::SEL_PLAIN;
                        o_cmd.out_last = 1'b1;
                    end
                end
            end
            tet_pkg::S_ESC: begin
                if (accept && i_stat.is_tick) begin
                    o_cmd.age_tick = 1'b1;
                    if (i_stat.age_expired) begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.out_sel  = tet_pkg::SEL_ESCKEY;
                        o_cmd.out_last = 1'b1;
                        n_state        = tet_pkg::S_NORMAL;
                    end
                end else if (accept) begin
                    if (i_stat.byte_intro) begin
                        o_cmd.seq_open = 1'b1;
                        n_state        = tet_pkg::S_SEQ;
                    end else if (i_stat.byte_str) begin
                        o_cmd.str_clr = 1'b1;
                        n_state       = tet_pkg::S_STR;
                    end else if (i_stat.byte_esc) begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.out_sel  = tet_pkg::SEL_ESCKEY;
                        o_cmd.out_last = 1'b1;
                        o_cmd.age_clr  = 1'b1;
                    end else begin
                        o_cmd.load_out  = 1'b1;
                        o_cmd.out_sel   = tet_pkg::SEL_ESCKEY;
                        o_cmd.hold_byte = 1'b1;
                        n_state         = tet_pkg::S_EMIT_BYTE;
                    end
                end
            end
            tet_pkg::S_SEQ: begin
                if (accept && !i_stat.is_tick) begin
                    if (i_stat.byte_final) begin
                        o_cmd.seq_final = 1'b1;
                        o_cmd.load_out  = 1'b1;
                        o_cmd.out_sel   = tet_pkg::SEL_PARAM_FIRST;
                        n_state = i_stat.final_multi ? tet_pkg::S_EMIT_PARAM
                                                     : tet_pkg::S_NORMAL;
                    end else begin
                        o_cmd.seq_store = 1'b1;
                    end
                end
            end
            tet_pkg::S_STR: begin
                if (accept && !i_stat.is_tick) begin
                    if (i_stat.byte_esc) begin
                        n_state = tet_pkg::S_STR_ESC;
                    end else if (i_stat.byte_bel || i_stat.str_full) begin
                        n_state = tet_pkg::S_NORMAL;
                    end else begin
                        o_cmd.str_inc = 1'b1;
                    end
                end
            end
            tet_pkg::S_STR_ESC: begin
                if (accept && !i_stat.is_tick) begin
                    n_state = i_stat.byte_st ? tet_pkg::S_NORMAL : tet_pkg::S_STR;
                end
            end
            tet_pkg::S_EMIT_BYTE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_sel  = tet_pkg::SEL_HELD_BYTE;
                    o_cmd.out_last = 1'b1;
                    n_state        = tet_pkg::S_NORMAL;
                end
            end
            tet_pkg::S_EMIT_PARAM: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out  = 1'b1;
                    o_cmd.out_sel   = tet_pkg::SEL_PARAM_NEXT;
                    o_cmd.emit_next = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = tet_pkg::S_NORMAL;
                    end
                end
            end
            default: begin
                n_state = tet_pkg::S_NORMAL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tet_pkg::S_NORMAL;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/tet_dp.sv
// ----------------------------------------------------------------------------
// tet_dp
// Tokenizer datapath: configuration registers, Escape age and string length
// counters, parameter parser and store, and the result output register.
// ----------------------------------------------------------------------------
module tet_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [tet_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_op,
    input  logic [7:0]                    i_byte,
    input  tet_pkg::t_dp_cmd              i_cmd,
    output tet_pkg::t_dp_stat             o_stat,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [1:0]                    o_kind,
    output logic [7:0]                    o_code,
    output logic                          o_intro,
    output logic [7:0]                    o_marker,
    output logic [tet_pkg::COUNT_W-1:0]   o_count,
    output logic [tet_pkg::INDEX_W-1:0]   o_index,
    output logic [tet_pkg::VALUE_W-1:0]   o_value,
    output logic                          o_last
);

    logic [tet_pkg::AGE_W-1:0]    r_esc_timeout;
    logic [tet_pkg::STR_W-1:0]    r_str_limit;
    logic [tet_pkg::AGE_W-1:0]    r_age;
    logic [tet_pkg::AGE_W-1:0]    n_age;
    logic [tet_pkg::STR_W-1:0]    r_str_count;
    logic [tet_pkg::STORED_W-1:0] r_stored;
    logic [tet_pkg::VALUE_W-1:0]  r_acc;
    logic                         r_have;
    logic [tet_pkg::COUNT_W-1:0]  r_found;
    logic                         r_intro;
    logic [7:0]                   r_first;
    logic [7:0]                   r_final;
    logic [7:0]                   r_held;
    logic [tet_pkg::INDEX_W-1:0]  r_emit_idx;
    logic [tet_pkg::VALUE_W-1:0]  r_store [tet_pkg::MAX_PARAMS];

    logic                         r_ov;
    logic [1:0]                   r_kind;
    logic [7:0]                   r_code;
    logic                         r_o_intro;
    logic [7:0]                   r_marker;
    logic [tet_pkg::COUNT_W-1:0]  r_count;
    logic [tet_pkg::INDEX_W-1:0]  r_index;
    logic [tet_pkg::VALUE_W-1:0]  r_value;
    logic                         r_last;

    logic [1:0]                   n_kind;
    logic [7:0]                   n_code;
    logic                         n_o_intro;
    logic [7:0]                   n_marker;
    logic [tet_pkg::COUNT_W-1:0]  n_count;
    logic [tet_pkg::INDEX_W-1:0]  n_index;
    logic [tet_pkg::VALUE_W-1:0]  n_value;
    logic                         n_last;

    logic                         is_digit;
    logic [19:0]                  acc_sum;
    logic [tet_pkg::VALUE_W-1:0]  acc_next;
    logic                         room;
    logic                         push;
    logic [tet_pkg::COUNT_W-1:0]  fin_count;
    logic                         emit_last;

    assign is_digit = (i_byte >= tet_pkg::CH_ZERO) && (i_byte <= tet_pkg::CH_NINE);
    assign acc_sum  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                    + {16'd0, i_byte[3:0]};
    assign acc_next = (acc_sum > {4'd0, tet_pkg::VALUE_MAX}) ? tet_pkg::VALUE_MAX
                                                             : acc_sum[15:0];
    assign room      = r_found < tet_pkg::COUNT_W'(tet_pkg::MAX_PARAMS);
    assign push      = r_have && room;
    assign fin_count = r_found + {{(tet_pkg::COUNT_W-1){1'b0}}, push};
    assign emit_last = ({1'b0, r_emit_idx} == (r_found - tet_pkg::COUNT_W'(1)));
    assign n_age     = (r_age == tet_pkg::AGE_MAX) ? r_age : r_age + tet_pkg::AGE_W'(1);

    always_comb begin
        o_stat.is_tick     = (i_op == tet_pkg::OP_TICK);
        o_stat.byte_esc    = (i_byte == tet_pkg::CH_ESC);
        o_stat.byte_intro  = (i_byte == tet_pkg::CH_CSI) || (i_byte == tet_pkg::CH_SS3);
        o_stat.byte_str    = (i_byte == tet_pkg::CH_APC) || (i_byte == tet_pkg::CH_DCS) ||
                             (i_byte == tet_pkg::CH_OSC) || (i_byte == tet_pkg::CH_PM);
        o_stat.byte_final  = (i_byte >= tet_pkg::FINAL_LO) && (i_byte <= tet_pkg::FINAL_HI);
        o_stat.byte_bel    = (i_byte == tet_pkg::CH_BEL);
        o_stat.byte_st     = (i_byte == tet_pkg::CH_ST);
        o_stat.age_expired = (n_age > r_esc_timeout);
        o_stat.str_full    = (r_str_count >= r_str_limit);
        o_stat.out_free    = !r_ov || i_out_ready;
        o_stat.final_multi = (fin_count > tet_pkg::COUNT_W'(1));
        o_stat.emit_last   = emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_timeout <= tet_pkg::ESC_TIMEOUT_RST;
            r_str_limit   <= tet_pkg::STR_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tet_pkg::CFG_ESC_TIMEOUT: r_esc_timeout <= i_cfg_data[tet_pkg::AGE_W-1:0];
                tet_pkg::CFG_STR_LIMIT:   r_str_limit   <= i_cfg_data[tet_pkg::STR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age       <= '0;
            r_str_count <= '0;
            r_stored    <= '0;
            r_acc       <= '0;
            r_have      <= 1'b0;
            r_found     <= '0;
            r_intro     <= 1'b0;
            r_first     <= '0;
            r_emit_idx  <= '0;
        end else begin
            if (i_cmd.age_clr) begin
                r_age <= '0;
            end else if (i_cmd.age_tick) begin
                r_age <= n_age;
            end
            if (i_cmd.str_clr) begin
                r_str_count <= '0;
            end else if (i_cmd.str_inc) begin
                r_str_count <= r_str_count + tet_pkg::STR_W'(1);
            end
            if (i_cmd.seq_open) begin
                r_intro  <= (i_byte == tet_pkg::CH_SS3);
                r_stored <= '0;
                r_first  <= '0;
                r_acc    <= '0;
                r_have   <= 1'b0;
                r_found  <= '0;
            end else if (i_cmd.seq_store) begin
                if (r_stored < tet_pkg::STORED_W'(tet_pkg::SEQ_BYTES)) begin
                    if (r_stored == '0) begin
                        r_first <= i_byte;
                    end
                    r_stored <= r_stored + tet_pkg::STORED_W'(1);
                    if (room && is_digit) begin
                        r_acc  <= acc_next;
                        r_have <= 1'b1;
                    end else if (room && (i_byte == tet_pkg::CH_SEMI)) begin
                        r_found <= fin_count;
                        r_acc   <= '0;
                        r_have  <= 1'b0;
                    end
                end
            end else if (i_cmd.seq_final) begin
                r_found    <= fin_count;
                r_acc      <= '0;
                r_have     <= 1'b0;
                r_emit_idx <= tet_pkg::INDEX_W'(1);
            end else if (i_cmd.emit_next) begin
                r_emit_idx <= r_emit_idx + tet_pkg::INDEX_W'(1);
            end
        end
    end

    // Parameter store and held bytes
    always_ff @(posedge i_clk) begin
        if ((i_cmd.seq_final || (i_cmd.seq_store && room && (i_byte == tet_pkg::CH_SEMI) &&
             (r_stored < tet_pkg::STORED_W'(tet_pkg::SEQ_BYTES)))) && push) begin
            r_store[r_found[tet_pkg::INDEX_W-1:0]] <= r_acc;
        end
        if (i_cmd.seq_final) begin
            r_final <= i_byte;
        end
        if (i_cmd.hold_byte) begin
            r_held <= i_byte;
        end
    end

    always_comb begin
        n_kind    = tet_pkg::KIND_PLAIN;
        n_code    = i_byte;
        n_o_intro = 1'b0;
        n_marker  = '0;
        n_count   = '0;
        n_index   = '0;
        n_value   = '0;
        n_last    = i_cmd.out_last;
        unique case (i_cmd.out_sel)
            tet_pkg::SEL_PLAIN: begin
                n_code = i_byte;
            end
            tet_pkg::SEL_ESCKEY: begin
                n_kind = tet_pkg::KIND_ESC;
                n_code = tet_pkg::CH_ESC;
            end
            tet_pkg::SEL_HELD_BYTE: begin
                n_code = r_held;
            end
            tet_pkg::SEL_PARAM_FIRST: begin
                n_kind    = tet_pkg::KIND_PARAM;
                n_o_intro = r_intro;
                n_marker  = r_first;
                n_count   = fin_count;
                n_last    = (fin_count <= tet_pkg::COUNT_W'(1));
                if (fin_count == '0) begin
                    n_value = '0;
                end else if (r_found == '0) begin
                    n_value = r_acc;
                end else begin
                    n_value = r_store[0];
                end
            end
            tet_pkg::SEL_PARAM_NEXT: begin
                n_kind    = tet_pkg::KIND_PARAM;
                n_code    = r_final;
                n_o_intro = r_intro;
                n_marker  = r_first;
                n_count   = r_found;
                n_index   = r_emit_idx;
                n_value   = r_store[r_emit_idx];
                n_last    = emit_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_kind    <= n_kind;
            r_code    <= n_code;
            r_o_intro <= n_o_intro;
            r_marker  <= n_marker;
            r_count   <= n_count;
            r_index   <= n_index;
            r_value   <= n_value;
            r_last    <= n_last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_kind      = r_kind;
    assign o_code      = r_code;
    assign o_intro     = r_o_intro;
    assign o_marker    = r_marker;
    assign o_count     = r_count;
    assign o_index     = r_index;
    assign o_value     = r_value;
    assign o_last      = r_last;

endmodule

>>> hdl/terminal_escape_tokenizer_core.sv
// ----------------------------------------------------------------------------
// terminal_escape_tokenizer_core
// Splits terminal input bytes and millisecond ticks into plain bytes, lone
// Escape keys and control sequence parameter beats.
// ----------------------------------------------------------------------------
// An input beat is taken whenever the parser is in a parsing state and the
// output register is free or being drained. A byte or tick that yields one
// result, or none, leaves the parser in a parsing state. ESC followed by an
// ordinary byte yields two result beats, and the input stalls after that byte
// is taken until the held byte is loaded into the output register; a sequence
// final byte with N parameters yields N beats (one when N is zero), and the
// input stalls after it is taken while the parameter store is read out one
// entry per cycle through the single output register, waiting while tready is low.
// ----------------------------------------------------------------------------
module terminal_escape_tokenizer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [tet_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // in_byte
    input  logic                          s_axis_tuser,   // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // code_byte, intro_ss3, marker, param_count, param_index, param_value, pad
    output logic [tet_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic [1:0]                    m_axis_tuser,   // kind
    output logic                          m_axis_tlast
);

    tet_pkg::t_dp_cmd             cmd;
    tet_pkg::t_dp_stat            stat;
    logic [7:0]                   code;
    logic                         intro;
    logic [7:0]                   marker;
    logic [tet_pkg::COUNT_W-1:0]  count;
    logic [tet_pkg::INDEX_W-1:0]  index;
    logic [tet_pkg::VALUE_W-1:0]  value;

    tet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tet_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_op        (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_kind      (m_axis_tuser),
        .o_code      (code),
        .o_intro     (intro),
        .o_marker    (marker),
        .o_count     (count),
        .o_index     (index),
        .o_value     (value),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, value, index, count, marker, intro, code};

endmodule

>>> bench/terminal_escape_tokenizer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// terminal_escape_tokenizer_checker
// Follows the configuration writes and both stream channels of the tokenizer.
// Every input beat is run through a local tokenizer, and the tokens it yields
// are queued. Every output beat is then compared against the oldest queued
// token. Failures and the number of tokens still awaited go to the top.
// ----------------------------------------------------------------------------
module terminal_escape_tokenizer_checker
    import tet_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_in_data,
    input  logic               i_in_user,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [TDATA_W-1:0] i_out_data,
    input  logic [1:0]         i_out_user,
    input  logic               i_out_last,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef enum logic [2:0] {
        SCAN_NORMAL,
        SCAN_ESC,
        SCAN_SEQ,
        SCAN_STR,
        SCAN_STR_ESC
    } t_scan;

    typedef struct packed {
        t_kind                kind;
        logic [7:0]           code;
        logic                 intro;
        logic [7:0]           marker;
        logic [COUNT_W-1:0]   count;
        logic [INDEX_W-1:0]   index;
        logic [VALUE_W-1:0]   value;
        logic                 last;
    } t_token;

    t_token               token_q[$];
    logic [AGE_W-1:0]     esc_timeout;
    logic [STR_W-1:0]     str_limit;
    t_scan                scan;
    logic [AGE_W-1:0]     esc_age;
    logic [STR_W-1:0]     str_len;
    logic [STORED_W-1:0]  seq_len;
    logic [VALUE_W-1:0]   param_mem [MAX_PARAMS];
    logic [VALUE_W-1:0]   digits;
    logic                 have_digits;
    logic [COUNT_W-1:0]   param_cnt;
    logic                 seq_ss3;
    logic [7:0]           seq_marker;
    int                   fails = 0;

    function automatic string show(input t_token t);
        return $sformatf({"kind %0d code %02h ss3 %0d marker %02h ",
                          "count %0d index %0d value %0d last %0d"},
                         t.kind, t.code, t.intro, t.marker, t.count, t.index, t.value, t.last);
    endfunction

    task automatic add_token(input t_kind k, input logic [7:0] c,
                             input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] val);
        t_token t;
        t = '0;
        t.kind = k;
        t.code = c;
        if (k == KIND_PARAM) begin
            t.intro  = seq_ss3;
            t.marker = seq_marker;
            t.count  = param_cnt;
            t.index  = idx;
            t.value  = val;
        end
        token_q.push_back(t);
    endtask

    task automatic close_param();
        if (have_digits && param_cnt < MAX_PARAMS) begin
            param_mem[param_cnt[INDEX_W-1:0]] = digits;
            param_cnt++;
        end
        digits      = '0;
        have_digits = 1'b0;
    endtask

    task automatic plain_byte(input logic [7:0] c);
        if (c == CH_ESC) begin
            scan    = SCAN_ESC;
            esc_age = '0;
        end else begin
            add_token(KIND_PLAIN, c, '0, '0);
        end
    endtask

    task automatic tokenize_beat(input logic op, input logic [7:0] c);
        int          first;
        logic [31:0] acc;
        t_token      tail;
        first = token_q.size();
        if (op == OP_TICK) begin
            if (scan == SCAN_ESC) begin
                if (esc_age != AGE_MAX) esc_age++;
                if (esc_age > esc_timeout) begin
                    add_token(KIND_ESC, CH_ESC, '0, '0);
                    scan = SCAN_NORMAL;
                end
            end
        end else begin
            case (scan)
                SCAN_NORMAL: plain_byte(c);
                SCAN_ESC: begin
                    if (c == CH_CSI || c == CH_SS3) begin
                        scan        = SCAN_SEQ;
                        seq_ss3     = (c == CH_SS3);
                        seq_len     = '0;
                        seq_marker  = '0;
                        digits      = '0;
                        have_digits = 1'b0;
                        param_cnt   = '0;
                    end else if (c == CH_APC || c == CH_DCS || c == CH_OSC || c == CH_PM) begin
                        scan    = SCAN_STR;
                        str_len = '0;
                    end else begin
                        add_token(KIND_ESC, CH_ESC, '0, '0);
                        scan = SCAN_NORMAL;
                        plain_byte(c);
                    end
                end
                SCAN_SEQ: begin
                    if (c >= FINAL_LO && c <= FINAL_HI) begin
                        close_param();
                        if (param_cnt == 0) begin
                            add_token(KIND_PARAM, c, '0, '0);
                        end else begin
                            for (int i = 0; i < param_cnt; i++)
                                add_token(KIND_PARAM, c, i[INDEX_W-1:0], param_mem[i]);
                        end
                        scan = SCAN_NORMAL;
                    end else if (seq_len < SEQ_BYTES) begin
                        if (seq_len == 0) seq_marker = c;
                        seq_len++;
                        if (param_cnt < MAX_PARAMS) begin
                            if (c >= CH_ZERO && c <= CH_NINE) begin
                                acc = 32'(digits) * 32'd10 + 32'(c - CH_ZERO);
                                digits = (acc > 32'(VALUE_MAX)) ? VALUE_MAX : acc[VALUE_W-1:0];
                                have_digits = 1'b1;
                            end else if (c == CH_SEMI) begin
                                close_param();
                            end
                        end
                    end
                end
                SCAN_STR: begin
                    if (c == CH_ESC) scan = SCAN_STR_ESC;
                    else if (c == CH_BEL) scan = SCAN_NORMAL;
                    else if (str_len >= str_limit) scan = SCAN_NORMAL;
                    else str_len++;
                end
                SCAN_STR_ESC: scan = (c == CH_ST) ? SCAN_NORMAL : SCAN_STR;
                default: scan = SCAN_NORMAL;
            endcase
        end
        if (token_q.size() > first) begin
            tail = token_q.pop_back();
            tail.last = 1'b1;
            token_q.push_back(tail);
        end
    endtask

    task automatic check_beat();
        t_token got, want;
        got.kind   = t_kind'(i_out_user);
        got.code   = i_out_data[7:0];
        got.intro  = i_out_data[8];
        got.marker = i_out_data[16:9];
        got.count  = i_out_data[21:17];
        got.index  = i_out_data[25:22];
        got.value  = i_out_data[41:26];
        got.last   = i_out_last;
        if (token_q.size() == 0) begin
            fails++;
            if (fails <= 10) $display("%0t: beat with none awaited: %s", $time, show(got));
        end else begin
            want = token_q.pop_front();
            if (got !== want) begin
                fails++;
                if (fails <= 10)
                    $display("%0t: mismatch\n  expected %s\n  actual   %s",
                             $time, show(want), show(got));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            token_q.delete();
            esc_timeout = ESC_TIMEOUT_RST;
            str_limit   = STR_LIMIT_RST;
            scan        = SCAN_NORMAL;
            esc_age     = '0;
            str_len     = '0;
            seq_len     = '0;
            digits      = '0;
            have_digits = 1'b0;
            param_cnt   = '0;
            seq_ss3     = 1'b0;
            seq_marker  = '0;
            foreach (param_mem[i]) param_mem[i] = '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ESC_TIMEOUT) esc_timeout = i_cfg_data[AGE_W-1:0];
                else str_limit = i_cfg_data[STR_W-1:0];
            end
            if (i_out_valid && i_out_ready) check_beat();
            if (i_in_valid && i_in_ready) tokenize_beat(i_in_user, i_in_data);
        end
        o_pending    <= token_q.size();
        o_fail_count <= fails;
    end

endmodule

>>> bench/terminal_escape_tokenizer_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// terminal_escape_tokenizer_core_test
// Drives the tokenizer with byte and tick beats: a directed opening that
// covers plain bytes, CSI and SS3 sequences, lone Escape keys and string
// sequences, then random well-formed and broken traffic under several
// register settings. Both stream sides idle at random. A separate checker
// predicts and compares every output beat.
// ----------------------------------------------------------------------------
module terminal_escape_tokenizer_core_test;
    import tet_pkg::*;

    localparam int STALL_LIMIT = 1000;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic               i_cfg_idx     = CFG_ESC_TIMEOUT;
    logic [CFG_W-1:0]   i_cfg_data    = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;
    logic               s_axis_tuser  = OP_BYTE;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [1:0]         m_axis_tuser;
    logic               m_axis_tlast;

    int               fail_count;
    int               pending;
    int               quiet_cycles = 0;
    int               bytes_sent   = 0;
    int               sink_wait    = 0;
    int               sink_gap;
    bit               src_calm     = 1'b0;
    bit               sink_calm    = 1'b0;
    bit               rush         = 1'b0;
    logic [AGE_W-1:0] cur_timeout  = ESC_TIMEOUT_RST;
    logic [STR_W-1:0] cur_limit    = STR_LIMIT_RST;

    terminal_escape_tokenizer_core DUT (.*);

    terminal_escape_tokenizer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_wait     <= 0;
        end else if (m_axis_tready) begin
            if (m_axis_tvalid) begin
                if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
                sink_gap = sink_calm ? 0 : $urandom_range(0, 10);
                if (sink_gap != 0) begin
                    m_axis_tready <= 1'b0;
                    sink_wait     <= sink_gap - 1;
                end
            end
        end else if (sink_wait == 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            sink_wait <= sink_wait - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_beat(input logic op, input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 29) == 0) src_calm = !src_calm;
        gap = (src_calm || rush) ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OP_BYTE) bytes_sent++;
    endtask

    task automatic send_esc();
        send_beat(OP_BYTE, CH_ESC);
    endtask

    task automatic send_tick();
        send_beat(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(OP_BYTE, s[i]);
    endtask

    function automatic logic [7:0] seq_noise();
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 8'h3f));
        return 8'($urandom_range(8'h7f, 8'hff));
    endfunction

    task automatic send_control_seq();
        int nparam, ndig;
        send_esc();
        send_beat(OP_BYTE, ($urandom_range(0, 3) == 0) ? CH_SS3 : CH_CSI);
        if ($urandom_range(0, 2) == 0) send_beat(OP_BYTE, 8'($urandom_range(8'h3c, 8'h3f)));
        nparam = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 4);
        for (int j = 0; j < nparam; j++) begin
            ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
            for (int d = 0; d < ndig; d++)
                send_beat(OP_BYTE, CH_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 9) == 0) send_beat(OP_BYTE, seq_noise());
            if ($urandom_range(0, 15) == 0) send_tick();
            if (j != nparam - 1) send_beat(OP_BYTE, CH_SEMI);
        end
        send_beat(OP_BYTE, FINAL_LO + 8'($urandom_range(0, FINAL_HI - FINAL_LO)));
    endtask

    task automatic send_string_seq();
        int         len;
        logic [7:0] b;
        send_esc();
        case ($urandom_range(0, 3))
            0:       send_beat(OP_BYTE, CH_APC);
            1:       send_beat(OP_BYTE, CH_DCS);
            2:       send_beat(OP_BYTE, CH_OSC);
            default: send_beat(OP_BYTE, CH_PM);
        endcase
        len = $urandom_range(0, (cur_limit > 10) ? 10 : int'(cur_limit) + 2);
        for (int j = 0; j < len; j++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_esc();
                b = 8'($urandom_range(0, 255));
                send_beat(OP_BYTE, (b == CH_ST) ? 8'h41 : b);
            end
            b = 8'($urandom_range(0, 255));
            send_beat(OP_BYTE, (b == CH_ESC || b == CH_BEL) ? 8'h20 : b);
        end
        case ($urandom_range(0, 2))
            0: send_beat(OP_BYTE, CH_BEL);
            1: begin
                send_esc();
                send_beat(OP_BYTE, CH_ST);
            end
            default: begin
                if (len <= cur_limit) send_beat(OP_BYTE, CH_BEL);
            end
        endcase
    endtask

    task automatic send_escape_wait();
        int n;
        send_esc();
        n = (cur_timeout < 40) ? $urandom_range(0, int'(cur_timeout) + 2) : $urandom_range(0, 6);
        repeat (n) send_tick();
        if ($urandom_range(0, 1) == 0) send_beat(OP_BYTE, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_random(input int n);
        int stop_at, pick;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                send_beat(OP_BYTE, 8'($urandom_range(0, 255)));
            end else if (pick < 55) begin
                send_control_seq();
            end else if (pick < 70) begin
                send_string_seq();
            end else if (pick < 85) begin
                send_escape_wait();
            end else if (pick < 92) begin
                send_tick();
            end else begin
                send_esc();
                send_beat(OP_BYTE, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic settle(input int tail);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [AGE_W-1:0] t, input logic [STR_W-1:0] l);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ESC_TIMEOUT;
        i_cfg_data <= CFG_W'(t);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_STR_LIMIT;
        i_cfg_data <= CFG_W'(l);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_timeout = t;
        cur_limit   = l;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, CSI with marker, SS3, lone Escape, strings ended by BEL and ST
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, 8'hff);
        send_esc();
        send_text("[?1;2m");
        send_esc();
        send_text("OA");
        send_esc();
        send_text("x");
        send_esc();
        send_esc();
        send_text("]0");
        send_beat(OP_BYTE, CH_BEL);
        send_esc();
        send_text("Pq");
        send_esc();
        send_text("\\");
        send_tick();
        run_random(30);

        settle(20);
        write_regs(16'd0, 24'd1);
        send_esc();
        send_tick();
        send_esc();
        send_text("]abc");
        run_random(30);

        // hold an Escape through a run of ticks under the widest timeout
        settle(20);
        write_regs(16'hffff, 24'hffffff);
        send_esc();
        rush = 1'b1;
        repeat (12) send_tick();
        rush = 1'b0;
        send_text("z");
        run_random(30);

        settle(20);
        write_regs(16'd3, 24'd5);
        send_esc();
        send_text("^");
        send_esc();
        send_text("ab");
        send_beat(OP_BYTE, CH_BEL);
        run_random(35);

        settle(20);
        write_regs(16'd0, 24'd0);
        send_esc();
        send_text("_ak");
        run_random(30);

        settle(40);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
